// File: rtl/core/fpa_pkg.sv
// shared constants, opcodes, error codes and item types of the fixed-point alu
// no dependencies
`default_nettype none
package fpa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 8;
  localparam int FUNC_BITS = 4;
  localparam int ERR_BITS = 2;
  localparam int QUO_BITS = WORD_BITS + FRAC_BITS;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int MAG_BITS = (PROD_BITS - FRAC_BITS > QUO_BITS + 1) ?
                            PROD_BITS - FRAC_BITS : QUO_BITS + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = 2;
  localparam int STAGES = QUO_BITS + 2;

  localparam logic [FUNC_BITS-1:0] OP_ADD      = 4'd0;
  localparam logic [FUNC_BITS-1:0] OP_SUB      = 4'd1;
  localparam logic [FUNC_BITS-1:0] OP_MUL      = 4'd2;
  localparam logic [FUNC_BITS-1:0] OP_DIV      = 4'd3;
  localparam logic [FUNC_BITS-1:0] OP_GT       = 4'd4;
  localparam logic [FUNC_BITS-1:0] OP_LT       = 4'd5;
  localparam logic [FUNC_BITS-1:0] OP_GE       = 4'd6;
  localparam logic [FUNC_BITS-1:0] OP_LE       = 4'd7;
  localparam logic [FUNC_BITS-1:0] OP_EQ       = 4'd8;
  localparam logic [FUNC_BITS-1:0] OP_NE       = 4'd9;
  localparam logic [FUNC_BITS-1:0] OP_MIN      = 4'd10;
  localparam logic [FUNC_BITS-1:0] OP_MAX      = 4'd11;
  localparam logic [FUNC_BITS-1:0] OP_INC      = 4'd12;
  localparam logic [FUNC_BITS-1:0] OP_DEC      = 4'd13;
  localparam logic [FUNC_BITS-1:0] OP_TO_INT   = 4'd14;
  localparam logic [FUNC_BITS-1:0] OP_FROM_INT = 4'd15;

  localparam logic [ERR_BITS-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_DIV_ZERO = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_OVERFLOW = 2'd2;

  // classified request, front to back
  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic                 na;
    logic                 nb;
    logic [WORD_BITS-1:0] ma;
    logic [WORD_BITS-1:0] mb;
    logic                 bzero;
  } fpa_item_t;

  // one slot of the execution pipeline
  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic                 neg;
    logic                 bzero;
    logic [WORD_BITS-1:0] val;
    logic                 cmp;
    logic [ERR_BITS-1:0]  err;
    logic [PROD_BITS-1:0] prod;
    logic [MAG_BITS-1:0]  mag;
    logic [QUO_BITS-1:0]  num;
    logic [WORD_BITS-1:0] rem;
    logic [QUO_BITS-1:0]  quo;
    logic [WORD_BITS-1:0] dvs;
  } fpa_stage_t;

  // most positive or most negative word
  function automatic logic [WORD_BITS-1:0] sat_word(input logic neg);
    sat_word = {neg, {(WORD_BITS-1){~neg}}};
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/fpa_front.sv
// front end: accepts requests and classifies operands (signs, magnitudes)
// depends on fpa_pkg
`default_nettype none
module fpa_front import fpa_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [FUNC_BITS-1:0]   in_func,
  input  wire logic [WORD_BITS-1:0]   in_a,
  input  wire logic [WORD_BITS-1:0]   in_b,
  output logic                        push,
  output fpa_item_t                   push_item,
  input  wire logic                   queue_full
);

  logic      held;
  fpa_item_t item;

  assign push      = held && !queue_full;
  assign in_ready  = !held || !queue_full;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.func  <= in_func;
      item.a     <= in_a;
      item.b     <= in_b;
      item.na    <= in_a[WORD_BITS-1];
      item.nb    <= in_b[WORD_BITS-1];
      item.ma    <= in_a[WORD_BITS-1] ? (~in_a + 1'b1) : in_a;
      item.mb    <= in_b[WORD_BITS-1] ? (~in_b + 1'b1) : in_b;
      item.bzero <= (in_b == '0);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fpa_queue.sv
// short fifo of classified requests between front and back
// depends on fpa_pkg
`default_nettype none
module fpa_queue import fpa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  fpa_item_t      push_item,
  output logic           full,
  input  wire logic      pop,
  output fpa_item_t      pop_item,
  output logic           empty
);

  fpa_item_t              slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QPTR_BITS:0]     count;

  assign full     = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fpa_back.sv
// back end: execution pipeline with multiplier, bit-per-stage divider and result register
// depends on fpa_pkg
`default_nettype none
module fpa_back import fpa_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   queue_empty,
  input  fpa_item_t                   queue_item,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [WORD_BITS-1:0]        out_value,
  output logic                        out_cmp,
  output logic [ERR_BITS-1:0]         out_err
);

  fpa_stage_t         st  [STAGES];
  fpa_stage_t         nx  [STAGES];
  logic [STAGES-1:0]  stv;
  logic               en;

  assign en  = !out_valid || out_ready;
  assign pop = en && !queue_empty;

  function automatic fpa_stage_t exec0(input fpa_item_t it);
    fpa_stage_t           s;
    logic [WORD_BITS-1:0] sum;
    logic [WORD_BITS-1:0] dif;
    logic [WORD_BITS-1:0] shl;
    logic                 lt;
    logic                 gt;
    s       = '0;
    s.func  = it.func;
    s.neg   = it.na ^ it.nb;
    s.bzero = it.bzero;
    s.err   = ERR_NONE;
    s.prod  = PROD_BITS'(it.ma) * PROD_BITS'(it.mb);
    s.num   = {it.ma, {FRAC_BITS{1'b0}}};
    s.dvs   = it.mb;
    sum = it.a + it.b;
    dif = it.a - it.b;
    shl = it.a << FRAC_BITS;
    lt  = $signed(it.a) < $signed(it.b);
    gt  = $signed(it.b) < $signed(it.a);
    unique case (it.func)
      OP_ADD: begin
        s.val = sum;
        if (it.na == it.nb && sum[WORD_BITS-1] != it.na) begin
          s.val = sat_word(it.na);
          s.err = ERR_OVERFLOW;
        end
      end
      OP_SUB: begin
        s.val = dif;
        if (it.na != it.nb && dif[WORD_BITS-1] != it.na) begin
          s.val = sat_word(it.na);
          s.err = ERR_OVERFLOW;
        end
      end
      OP_GT: s.cmp = gt;
      OP_LT: s.cmp = lt;
      OP_GE: s.cmp = !lt;
      OP_LE: s.cmp = !gt;
      OP_EQ: s.cmp = (it.a == it.b);
      OP_NE: s.cmp = (it.a != it.b);
      OP_MIN: s.val = lt ? it.a : it.b;
      OP_MAX: s.val = gt ? it.a : it.b;
      OP_INC: begin
        s.val = it.a + 1'b1;
        if (it.a == sat_word(1'b0)) begin
          s.val = it.a;
          s.err = ERR_OVERFLOW;
        end
      end
      OP_DEC: begin
        s.val = it.a - 1'b1;
        if (it.a == sat_word(1'b1)) begin
          s.val = it.a;
          s.err = ERR_OVERFLOW;
        end
      end
      OP_TO_INT: s.val = WORD_BITS'($signed(it.a) >>> FRAC_BITS);
      OP_FROM_INT: begin
        s.val = shl;
        if (WORD_BITS'($signed(shl) >>> FRAC_BITS) != it.a) begin
          s.val = sat_word(it.na);
          s.err = ERR_OVERFLOW;
        end
      end
      default: s.val = '0;
    endcase
    return s;
  endfunction

  // one restoring-division bit
  function automatic fpa_stage_t div_step(input fpa_stage_t p);
    fpa_stage_t         s;
    logic [WORD_BITS:0] sh;
    logic               take;
    s    = p;
    sh   = {p.rem, p.num[QUO_BITS-1]};
    take = (sh >= {1'b0, p.dvs});
    s.rem = take ? WORD_BITS'(sh - {1'b0, p.dvs}) : WORD_BITS'(sh);
    s.num = {p.num[QUO_BITS-2:0], 1'b0};
    s.quo = {p.quo[QUO_BITS-2:0], take};
    return s;
  endfunction

  function automatic fpa_stage_t mul_round(input fpa_stage_t p);
    fpa_stage_t           s;
    logic [PROD_BITS:0]   rnd;
    s   = p;
    rnd = {1'b0, p.prod} + (PROD_BITS+1)'(1 << (FRAC_BITS - 1));
    s.mag = MAG_BITS'(rnd >> FRAC_BITS);
    return s;
  endfunction

  function automatic fpa_stage_t div_round(input fpa_stage_t p);
    fpa_stage_t s;
    logic       up;
    s  = p;
    up = ({p.rem, 1'b0} >= {1'b0, p.dvs});
    if (p.func == OP_DIV) begin
      s.mag = MAG_BITS'(p.quo) + MAG_BITS'(up);
    end
    return s;
  endfunction

  always_comb begin
    nx[0] = exec0(queue_item);
    for (int k = 1; k <= QUO_BITS; k++) begin
      nx[k] = div_step(st[k-1]);
    end
    nx[1] = mul_round(div_step(st[0]));
    nx[STAGES-1] = div_round(st[STAGES-2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stv       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      stv       <= {stv[STAGES-2:0], pop};
      out_valid <= stv[STAGES-1];
    end
  end

  logic [WORD_BITS-1:0] limit;
  logic [WORD_BITS-1:0] low_mag;
  fpa_stage_t           last;

  assign last    = st[STAGES-1];
  assign limit   = last.neg ? sat_word(1'b1) : sat_word(1'b0);
  assign low_mag = last.mag[WORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STAGES; k++) begin
        st[k] <= nx[k];
      end
      out_cmp   <= last.cmp;
      out_value <= last.val;
      out_err   <= last.err;
      if (last.func == OP_MUL || last.func == OP_DIV) begin
        if (last.func == OP_DIV && last.bzero) begin
          out_value <= '0;
          out_err   <= ERR_DIV_ZERO;
        end else if (last.mag > MAG_BITS'(limit)) begin
          out_value <= limit;
          out_err   <= ERR_OVERFLOW;
        end else begin
          out_value <= last.neg ? (~low_mag + 1'b1) : low_mag;
          out_err   <= ERR_NONE;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fixed_point_alu_q8_core.sv
// top level of the signed q24.8 fixed-point alu
// depends on fpa_pkg, fpa_front, fpa_queue, fpa_back
//
// channel  | direction | tdata                          | tuser
// ---------+-----------+--------------------------------+-------------------------------
// s_axis   | in        | [31:0] operand_a [63:32] op_b  | [3:0] func
// m_axis   | out       | [31:0] value                   | [0] compare_true [2:1] error
//
// one request per cycle sustained while m_axis does not stall; an accepted request
// passes the front register, a queue slot, one 32x32 multiply stage, 40 divider
// stages (one quotient bit each), a rounding stage and the result register
// rst is synchronous and clears all valid bits; payload registers are not reset
// a stall on m_axis freezes the pipeline, the 4-deep queue and front register
// keep taking requests until the queue fills
`default_nettype none
module fixed_point_alu_q8_core import fpa_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [2*WORD_BITS-1:0]   s_axis_tdata,  // operand_a, operand_b
  input  wire logic [FUNC_BITS-1:0]     s_axis_tuser,  // func
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [WORD_BITS-1:0]          m_axis_tdata,  // value
  output logic [ERR_BITS:0]             m_axis_tuser   // compare_true, error
);

  // front to queue
  logic      push;
  fpa_item_t push_item;
  logic      queue_full;

  // queue to back
  logic      pop;
  fpa_item_t pop_item;
  logic      queue_empty;

  logic                 res_cmp;
  logic [ERR_BITS-1:0]  res_err;

  // request intake and operand classification
  fpa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_func    (s_axis_tuser),
    .in_a       (s_axis_tdata[WORD_BITS-1:0]),
    .in_b       (s_axis_tdata[2*WORD_BITS-1:WORD_BITS]),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  // decouples intake from execution
  fpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (queue_empty)
  );

  // execution pipeline and result register
  fpa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_item  (pop_item),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_value   (m_axis_tdata),
    .out_cmp     (res_cmp),
    .out_err     (res_err)
  );

  assign m_axis_tuser = {res_err, res_cmp};

endmodule
`default_nettype wire
